[rtl/core/grst_pkg.sv]
// shared types and constants of the grid range sum tree
package grst_pkg;

  localparam int COORD_W = 7;
  localparam int VALUE_W = 16;
  localparam int SUM_W   = 28;

  localparam logic CMD_SET   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic               command;
    logic [COORD_W-1:0] row_first;
    logic [COORD_W-1:0] col_first;
    logic [COORD_W-1:0] row_last;
    logic [COORD_W-1:0] col_last;
    logic [VALUE_W-1:0] cell_value;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] range_sum;
    logic             bad_coordinate;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW_RD,
    ST_ROW_WR,
    ST_COL_RD,
    ST_COL_WR,
    ST_QR_LO,
    ST_QR_HI,
    ST_QR_END,
    ST_QC,
    ST_Q_DONE,
    ST_RESULT
  } state_t;

endpackage

[rtl/core/grid_range_sum_tree.sv]
// top level: two-dimensional segment tree of range sums over a SIDE by SIDE grid
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   grst_pkg::in_item_t   (command, coordinates, value)
//   out_     output     out_valid / out_stall grst_pkg::out_item_t  (range_sum, bad_coordinate)
//
// one item at a time; RW = clog2(2*SIDE) tree levels per dimension
// update: the leaf write, then a step that reads both children and one that writes their sum
//   for each of the other RW*RW-1 ancestor nodes
// query: a column walk of one level per cycle for each selected tree row, between the row steps;
//   each walk step reads both edge nodes on the two read ports of the store
// reset runs a clearing pass over all 4^RW entries, no item taken
// a finished result waits in the output register; in_stall is low whenever the engine is idle
module grid_range_sum_tree #(
  parameter int SIDE = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  grst_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output grst_pkg::out_item_t  out_item
);
  import grst_pkg::*;

  // tree index width per dimension and flat store address width
  localparam int RW = $clog2(2 * SIDE);
  localparam int AW = 2 * RW;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;              // where a column walk returns to

  logic [AW-1:0] clr_r, clr_nxt;

  // update walk
  logic [RW-1:0] r_r, r_nxt;           // leaf row
  logic [RW-1:0] q_r, q_nxt;           // current column node
  logic [RW-1:0] p_r, p_nxt;           // current row ancestor

  // query walk
  logic [RW-1:0] r1_r, r1_nxt;
  logic [RW-1:0] r2_r, r2_nxt;
  logic [RW-1:0] c1_r, c1_nxt;
  logic [RW-1:0] c2_r, c2_nxt;
  logic [RW-1:0] lo_r, lo_nxt;
  logic [RW-1:0] hi_r, hi_nxt;
  logic [RW-1:0] cur_r, cur_nxt;       // tree row being walked

  logic [SUM_W-1:0] acc_r, acc_nxt;
  logic             bad_r, bad_nxt;
  logic             va_r, vb_r;        // read data on port a/b belongs to the query sum
  logic             rd_a_use, rd_b_use;

  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  // store ports
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [SUM_W-1:0] wr_data;
  logic [AW-1:0]    rd_a_addr, rd_b_addr;
  logic [SUM_W-1:0] rd_a_data, rd_b_data;

  logic             in_fire;
  logic             out_free;
  logic             rf_ok, cf_ok, rl_ok, cl_ok;
  logic [RW-1:0]    leaf_r, leaf_c;

  // 1-based coordinate to leaf index
  function automatic logic [RW-1:0] to_leaf(input logic [COORD_W-1:0] v);
    return RW'(32'(v) + SIDE - 1);
  endfunction

  function automatic logic coord_ok(input logic [COORD_W-1:0] v);
    return (v != '0) && (32'(v) <= SIDE);
  endfunction

  grst_node_mem #(
    .AW(AW)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_a_addr(rd_a_addr),
    .rd_b_addr(rd_b_addr),
    .rd_a_data(rd_a_data),
    .rd_b_data(rd_b_data)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign rf_ok  = coord_ok(in_item.row_first);
  assign cf_ok  = coord_ok(in_item.col_first);
  assign rl_ok  = coord_ok(in_item.row_last);
  assign cl_ok  = coord_ok(in_item.col_last);
  assign leaf_r = to_leaf(in_item.row_first);
  assign leaf_c = to_leaf(in_item.col_first);

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    clr_nxt       = clr_r;
    r_nxt         = r_r;
    q_nxt         = q_r;
    p_nxt         = p_r;
    r1_nxt        = r1_r;
    r2_nxt        = r2_r;
    c1_nxt        = c1_r;
    c2_nxt        = c2_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    cur_nxt       = cur_r;
    bad_nxt       = bad_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_a_addr     = '0;
    rd_b_addr     = '0;
    rd_a_use      = 1'b0;
    rd_b_use      = 1'b0;
    // query reads land in the cycle after issue and fold into the sum
    acc_nxt = acc_r + (va_r ? rd_a_data : '0) + (vb_r ? rd_b_data : '0);

    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          acc_nxt = '0;
          bad_nxt = 1'b0;
          if (in_item.command == CMD_SET) begin
            if (!rf_ok || !cf_ok) begin
              bad_nxt   = 1'b1;
              state_nxt = ST_RESULT;
            end else begin
              // leaf write now, then the ancestors of that node
              wr_en   = 1'b1;
              wr_addr = {leaf_r, leaf_c};
              wr_data = SUM_W'(in_item.cell_value);
              r_nxt   = leaf_r;
              q_nxt   = leaf_c;
              if ((leaf_r >> 1) != '0) begin
                p_nxt     = leaf_r >> 1;
                state_nxt = ST_ROW_RD;
              end else if ((leaf_c >> 1) != '0) begin
                q_nxt     = leaf_c >> 1;
                state_nxt = ST_COL_RD;
              end else begin
                state_nxt = ST_IDLE;
              end
            end
          end else begin
            if (!rf_ok || !cf_ok || !rl_ok || !cl_ok) begin
              bad_nxt   = 1'b1;
              state_nxt = ST_RESULT;
            end else begin
              r1_nxt    = leaf_r;
              r2_nxt    = to_leaf(in_item.row_last);
              c1_nxt    = leaf_c;
              c2_nxt    = to_leaf(in_item.col_last);
              state_nxt = ST_QR_LO;
            end
          end
        end
      end

      // row ancestor (p, q) = (2p, q) + (2p+1, q)
      ST_ROW_RD: begin
        rd_a_addr = {RW'(p_r << 1), q_r};
        rd_b_addr = {RW'(p_r << 1) | RW'(1), q_r};
        state_nxt = ST_ROW_WR;
      end

      ST_ROW_WR: begin
        wr_en   = 1'b1;
        wr_addr = {p_r, q_r};
        wr_data = rd_a_data + rd_b_data;
        if ((p_r >> 1) != '0) begin
          p_nxt     = p_r >> 1;
          state_nxt = ST_ROW_RD;
        end else if ((q_r >> 1) != '0) begin
          q_nxt     = q_r >> 1;
          state_nxt = ST_COL_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      // column ancestor (r, q) = (r, 2q) + (r, 2q+1)
      ST_COL_RD: begin
        rd_a_addr = {r_r, RW'(q_r << 1)};
        rd_b_addr = {r_r, RW'(q_r << 1) | RW'(1)};
        state_nxt = ST_COL_WR;
      end

      ST_COL_WR: begin
        wr_en   = 1'b1;
        wr_addr = {r_r, q_r};
        wr_data = rd_a_data + rd_b_data;
        if ((r_r >> 1) != '0) begin
          p_nxt     = r_r >> 1;
          state_nxt = ST_ROW_RD;
        end else if ((q_r >> 1) != '0) begin
          q_nxt     = q_r >> 1;
          state_nxt = ST_COL_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      // row decomposition: low edge of the current level
      ST_QR_LO: begin
        if (r1_r < r2_r) begin
          if (r1_r[0]) begin
            cur_nxt   = r1_r;
            lo_nxt    = c1_r;
            hi_nxt    = c2_r;
            ret_nxt   = ST_QR_HI;
            r1_nxt    = r1_r + RW'(1);
            state_nxt = ST_QC;
          end else begin
            state_nxt = ST_QR_HI;
          end
        end else begin
          state_nxt = ST_QR_END;
        end
      end

      // high edge, then up one level
      ST_QR_HI: begin
        r1_nxt = r1_r >> 1;
        if (!r2_r[0]) begin
          cur_nxt   = r2_r;
          lo_nxt    = c1_r;
          hi_nxt    = c2_r;
          ret_nxt   = ST_QR_LO;
          r2_nxt    = (r2_r - RW'(1)) >> 1;
          state_nxt = ST_QC;
        end else begin
          r2_nxt    = r2_r >> 1;
          state_nxt = ST_QR_LO;
        end
      end

      // single row left when the edges meet
      ST_QR_END: begin
        if (r1_r == r2_r) begin
          cur_nxt   = r1_r;
          lo_nxt    = c1_r;
          hi_nxt    = c2_r;
          ret_nxt   = ST_Q_DONE;
          state_nxt = ST_QC;
        end else begin
          state_nxt = ST_Q_DONE;
        end
      end

      // column decomposition of tree row cur, one level per cycle
      ST_QC: begin
        rd_a_addr = {cur_r, lo_r};
        rd_b_addr = {cur_r, hi_r};
        if (lo_r < hi_r) begin
          rd_a_use = lo_r[0];
          rd_b_use = !hi_r[0];
          lo_nxt   = (lo_r + RW'(lo_r[0])) >> 1;
          hi_nxt   = (hi_r - RW'(!hi_r[0])) >> 1;
        end else begin
          rd_a_use  = (lo_r == hi_r);
          state_nxt = ret_r;
        end
      end

      // last reads fold into the sum here
      ST_Q_DONE: begin
        state_nxt = ST_RESULT;
      end

      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_item_nxt.range_sum      = bad_r ? '0 : acc_r;
          out_item_nxt.bad_coordinate = bad_r;
          state_nxt                   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      ret_r       <= ST_IDLE;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      va_r        <= rd_a_use;
      vb_r        <= rd_b_use;
      ret_r       <= ret_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r        <= r_nxt;
    q_r        <= q_nxt;
    p_r        <= p_nxt;
    r1_r       <= r1_nxt;
    r2_r       <= r2_nxt;
    c1_r       <= c1_nxt;
    c2_r       <= c2_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    cur_r      <= cur_nxt;
    acc_r      <= acc_nxt;
    bad_r      <= bad_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

[rtl/core/grst_node_mem.sv]
// node sum store: one write port, two registered read ports
module grst_node_mem #(
  parameter int AW = 14
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [grst_pkg::SUM_W-1:0] wr_data,
  input  logic [AW-1:0]             rd_a_addr,
  input  logic [AW-1:0]             rd_b_addr,
  output logic [grst_pkg::SUM_W-1:0] rd_a_data,
  output logic [grst_pkg::SUM_W-1:0] rd_b_data
);
  import grst_pkg::*;

  localparam int DEPTH = 1 << AW;

  logic [SUM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule
